// File: rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP response header parser package
// Character codes, line length limits and the status line prefix.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned COL_W = 4;
  localparam logic [COL_W-1:0] COL_MAX        = 4'd15;
  localparam logic [COL_W-1:0] COL_VERSION    = 4'd7;
  localparam logic [COL_W-1:0] COL_SP1        = 4'd8;
  localparam logic [COL_W-1:0] COL_CODE_LAST  = 4'd11;
  localparam logic [COL_W-1:0] COL_SP2        = 4'd12;
  localparam logic [COL_W-1:0] STATUS_MIN_COL = 4'd15;

  localparam int unsigned CODE_W = 10;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hrhp_in_if.sv
// ----------------------------------------------------------------------------
// HTTP response header parser input channel
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_response;

  modport source (output valid, output data_byte, output new_response, input ready);
  modport sink   (input valid, input data_byte, input new_response, output ready);
endinterface

`default_nettype wire

// File: rtl/hrhp_out_if.sv
// ----------------------------------------------------------------------------
// HTTP response header parser result channel
// Valid/ready channel carrying one classified byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrhp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_body;
  logic       line_end;
  logic       headers_done;
  logic       parse_error;
  logic       minor_version;
  logic [9:0] status_code;

  modport source (output valid, output out_byte, output is_body, output line_end,
                  output headers_done, output parse_error, output minor_version,
                  output status_code, input ready);
  modport sink   (input valid, input out_byte, input is_body, input line_end,
                  input headers_done, input parse_error, input minor_version,
                  input status_code, output ready);
endinterface

`default_nettype wire

// File: rtl/http_response_header_parser.sv
// Result valid rises in the cycle after an input item is accepted.
// Throughput: one byte per cycle while the result side takes each item; the
// per-byte state update (phase, column, status code accumulator) is combinational.
// Input ready stays high while the result register is empty or being taken.
// Reset: synchronous active-low rst_n returns to the status line phase and
// empties the result register.
// ----------------------------------------------------------------------------
// HTTP response header parser
// Checks the status line and header lines byte by byte, captures version
// and status code, and marks body bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_header_parser
  import hrhp_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  hrhp_in_if.sink      in_if,
  hrhp_out_if.source   out_if
);

  typedef enum logic [1:0] {
    PH_STATUS  = 2'd0,
    PH_HEADERS = 2'd1,
    PH_BODY    = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [COL_W-1:0]   column_r, column_nxt;
  logic               prev_cr_r, prev_cr_nxt;
  logic               prev_sp_r, prev_sp_nxt;
  logic               line_bad_r, line_bad_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic               ver_r, ver_nxt;

  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               is_body_r, is_body_nxt;
  logic               line_end_r, line_end_nxt;
  logic               hdone_r, hdone_nxt;
  logic               error_r;
  logic               minor_r;
  logic [CODE_W-1:0]  status_r;

  phase_t             ph_c;
  logic [COL_W-1:0]   col_c;
  logic               prev_cr_c, prev_sp_c, line_bad_c;
  logic [CODE_W-1:0]  code_c;
  logic               ver_c;
  logic [7:0]         b;
  logic               accept;
  logic               line_ok;
  logic               shown;

  assign b           = in_if.data_byte;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    if (in_if.new_response) begin
      ph_c       = PH_STATUS;
      col_c      = '0;
      prev_cr_c  = 1'b0;
      prev_sp_c  = 1'b0;
      line_bad_c = 1'b0;
      code_c     = '0;
      ver_c      = 1'b0;
    end else begin
      ph_c       = phase_r;
      col_c      = column_r;
      prev_cr_c  = prev_cr_r;
      prev_sp_c  = prev_sp_r;
      line_bad_c = line_bad_r;
      code_c     = code_r;
      ver_c      = ver_r;
    end

    phase_nxt    = ph_c;
    column_nxt   = col_c;
    prev_cr_nxt  = prev_cr_c;
    prev_sp_nxt  = prev_sp_c;
    line_bad_nxt = line_bad_c;
    code_nxt     = code_c;
    ver_nxt      = ver_c;
    is_body_nxt  = 1'b0;
    line_end_nxt = 1'b0;
    hdone_nxt    = 1'b0;
    line_ok      = 1'b0;

    unique case (ph_c)
      PH_BODY: begin
        is_body_nxt = 1'b1;
      end
      PH_STATUS, PH_HEADERS: begin
        if (b == CH_LF) begin
          line_ok = !line_bad_c && prev_cr_c;
          if (ph_c == PH_STATUS) begin
            line_ok = line_ok && (col_c >= STATUS_MIN_COL) && !prev_sp_c;
          end
          if (line_ok) begin
            line_end_nxt = 1'b1;
            if (ph_c == PH_STATUS) begin
              phase_nxt = PH_HEADERS;
            end else if (col_c == COL_W'(1)) begin
              hdone_nxt = 1'b1;
              phase_nxt = PH_BODY;
            end
          end else begin
            phase_nxt = PH_ERROR;
          end
          column_nxt   = '0;
          prev_cr_nxt  = 1'b0;
          prev_sp_nxt  = 1'b0;
          line_bad_nxt = 1'b0;
        end else begin
          if (ph_c == PH_STATUS) begin
            if (prev_cr_c) begin
              line_bad_nxt = 1'b1;
            end
            if (b != CH_CR) begin
              priority if (col_c < COL_VERSION) begin
                if (b != prefix_char(col_c[2:0])) line_bad_nxt = 1'b1;
              end else if (col_c == COL_VERSION) begin
                if (b == CH_ZERO || b == CH_ONE) ver_nxt = b[0];
                else line_bad_nxt = 1'b1;
              end else if (col_c == COL_SP1) begin
                if (b != CH_SP) line_bad_nxt = 1'b1;
              end else if (col_c <= COL_CODE_LAST) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                  code_nxt = {code_c[CODE_W-4:0], 3'b000} + {code_c[CODE_W-2:0], 1'b0}
                             + CODE_W'(b[3:0]);
                end else begin
                  line_bad_nxt = 1'b1;
                end
              end else if (col_c == COL_SP2) begin
                if (b != CH_SP || code_c == '0) line_bad_nxt = 1'b1;
              end else begin
                if (b < CH_SP || b > CH_TILDE) line_bad_nxt = 1'b1;
              end
            end
          end else if ((b < CH_SP && b != CH_CR) || b > CH_TILDE) begin
            line_bad_nxt = 1'b1;
          end
          prev_cr_nxt = (b == CH_CR);
          if (b != CH_CR) begin
            prev_sp_nxt = (b == CH_SP);
          end
          if (col_c < COL_MAX) begin
            column_nxt = col_c + COL_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    shown = (phase_nxt == PH_HEADERS) || (phase_nxt == PH_BODY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STATUS;
      column_r    <= '0;
      prev_cr_r   <= 1'b0;
      prev_sp_r   <= 1'b0;
      line_bad_r  <= 1'b0;
      code_r      <= '0;
      ver_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        column_r    <= column_nxt;
        prev_cr_r   <= prev_cr_nxt;
        prev_sp_r   <= prev_sp_nxt;
        line_bad_r  <= line_bad_nxt;
        code_r      <= code_nxt;
        ver_r       <= ver_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= b;
      is_body_r  <= is_body_nxt;
      line_end_r <= line_end_nxt;
      hdone_r    <= hdone_nxt;
      error_r    <= (phase_nxt == PH_ERROR);
      minor_r    <= shown ? ver_nxt : 1'b0;
      status_r   <= shown ? code_nxt : '0;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_byte      = out_byte_r;
  assign out_if.is_body       = is_body_r;
  assign out_if.line_end      = line_end_r;
  assign out_if.headers_done  = hdone_r;
  assign out_if.parse_error   = error_r;
  assign out_if.minor_version = minor_r;
  assign out_if.status_code   = status_r;

endmodule

`default_nettype wire

// File: rtl/hrhp_checker.sv
// ----------------------------------------------------------------------------
// HTTP response header parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       is_body,
  input wire       line_end,
  input wire       headers_done,
  input wire       parse_error,
  input wire       minor_version,
  input wire [9:0] status_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(line_end)
      && $stable(parse_error) && $stable(status_code))
    else $error("result item changed while stalled");

  a_hdone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && headers_done |-> line_end && !parse_error && !is_body)
    else $error("headers done without a clean line end");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && parse_error |-> !line_end && !is_body && !minor_version
      && status_code == 10'd0)
    else $error("error item carries flags or captured fields");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_byte      (out_if.out_byte),
  .is_body       (out_if.is_body),
  .line_end      (out_if.line_end),
  .headers_done  (out_if.headers_done),
  .parse_error   (out_if.parse_error),
  .minor_version (out_if.minor_version),
  .status_code   (out_if.status_code)
);

`default_nettype wire

// File: sim/http_response_header_parser_tb.sv
// ----------------------------------------------------------------------------
// HTTP response header parser testbench
// Streams well-formed and damaged responses byte by byte through the parser,
// with random gaps on the input side and random stalls on the result side.
// Every result is checked field by field against a cycle-free model of the
// status line, header line and body classification.
// ----------------------------------------------------------------------------

module http_response_header_parser_tb;
  import hrhp_pkg::*;

  typedef enum logic [1:0] {PH_STATUS, PH_HEADERS, PH_BODY, PH_ERROR} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_body;
    logic       line_end;
    logic       headers_done;
    logic       parse_error;
    logic       minor_version;
    logic [9:0] status_code;
  } byte_class_t;

  localparam logic [55:0] STATUS_PREFIX = "HTTP/1.";
  localparam int unsigned RANDOM_ITEMS  = 800;
  localparam int unsigned DRAIN_EVERY   = 300;

  logic clk = 1'b0;
  logic rst_n;

  hrhp_in_if  in_if ();
  hrhp_out_if out_if ();

  http_response_header_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  rx_item_t    rx_bytes[$];
  byte_class_t predicted_bytes[$];
  int unsigned total_items;
  int unsigned accepted_cnt;
  int unsigned taken_cnt;
  int unsigned mismatches;
  int          send_wait;
  int          take_wait;

  parse_phase_t hp_phase;
  logic [3:0]   hp_column;
  logic         hp_after_cr;
  logic         hp_after_space;
  logic         hp_line_bad;
  logic [9:0]   hp_code;
  logic         hp_version;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_line();
    hp_column      = '0;
    hp_after_cr    = 1'b0;
    hp_after_space = 1'b0;
    hp_line_bad    = 1'b0;
  endfunction

  function automatic void restart_parse();
    hp_phase   = PH_STATUS;
    hp_code    = '0;
    hp_version = 1'b0;
    clear_line();
  endfunction

  function automatic byte_class_t predict_parse(input logic [7:0] b, input logic restart);
    byte_class_t r;
    logic        ok;
    if (restart) restart_parse();
    r = '0;
    r.out_byte = b;
    if (hp_phase == PH_BODY) begin
      r.is_body = 1'b1;
    end else if (hp_phase != PH_ERROR) begin
      if (b == CH_LF) begin
        ok = !hp_line_bad && hp_after_cr;
        if (hp_phase == PH_STATUS) ok = ok && hp_column >= STATUS_MIN_COL && !hp_after_space;
        if (ok) begin
          r.line_end = 1'b1;
          if (hp_phase == PH_STATUS) begin
            hp_phase = PH_HEADERS;
          end else if (hp_column == 4'd1) begin
            r.headers_done = 1'b1;
            hp_phase       = PH_BODY;
          end
        end else begin
          hp_phase = PH_ERROR;
        end
        clear_line();
      end else begin
        if (hp_phase == PH_STATUS) begin
          if (hp_after_cr) hp_line_bad = 1'b1;
          if (b != CH_CR) begin
            if (hp_column < COL_VERSION) begin
              if (b != STATUS_PREFIX[8*(6-hp_column) +: 8]) hp_line_bad = 1'b1;
            end else if (hp_column == COL_VERSION) begin
              if (b == CH_ZERO || b == CH_ONE) hp_version = b[0];
              else hp_line_bad = 1'b1;
            end else if (hp_column == COL_SP1) begin
              if (b != CH_SP) hp_line_bad = 1'b1;
            end else if (hp_column <= COL_CODE_LAST) begin
              if (b >= CH_ZERO && b <= CH_NINE) hp_code = 10'(hp_code * 10 + (b - CH_ZERO));
              else hp_line_bad = 1'b1;
            end else if (hp_column == COL_SP2) begin
              if (b != CH_SP || hp_code == '0) hp_line_bad = 1'b1;
            end else if (b < CH_SP || b > CH_TILDE) begin
              hp_line_bad = 1'b1;
            end
          end
        end else if ((b < CH_SP && b != CH_CR) || b > CH_TILDE) begin
          hp_line_bad = 1'b1;
        end
        hp_after_cr = (b == CH_CR);
        if (b != CH_CR) hp_after_space = (b == CH_SP);
        if (hp_column != COL_MAX) hp_column = hp_column + 4'd1;
      end
    end
    r.parse_error = (hp_phase == PH_ERROR);
    if (hp_phase == PH_HEADERS || hp_phase == PH_BODY) begin
      r.minor_version = hp_version;
      r.status_code   = hp_code;
    end
    return r;
  endfunction

  function automatic int draw_wait(input int unsigned n);
    case ((n / 64) % 3)
      0:       return 0;
      1:       return $urandom_range(0, 12);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(CH_SP, CH_TILDE));
  endfunction

  task automatic add_item(input logic [7:0] b, input logic restart);
    rx_item_t it;
    it.data    = b;
    it.restart = restart;
    rx_bytes.push_back(it);
  endtask

  task automatic add_text(input string s, input logic restart);
    for (int i = 0; i < s.len(); i++) add_item(s[i], restart && i == 0);
  endtask

  task automatic add_crlf();
    add_item(CH_CR, 1'b0);
    add_item(CH_LF, 1'b0);
  endtask

  task automatic add_response();
    logic [7:0] r[$];
    int         len;
    int         pos;
    int         n_hdr;
    logic       first_restart;
    for (int i = 0; i < 7; i++) r.push_back(STATUS_PREFIX[8*(6-i) +: 8]);
    if ($urandom_range(0, 7) == 0) r.push_back(8'($urandom_range(0, 255)));
    else r.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
    r.push_back(CH_SP);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 9) == 0) r.push_back(CH_ZERO);
      else r.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end
    r.push_back(CH_SP);
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) r.push_back(printable_char());
    if (len > 0 && $urandom_range(0, 9) == 0) r[r.size()-1] = CH_SP;
    r.push_back(CH_CR);
    r.push_back(CH_LF);
    n_hdr = $urandom_range(0, 3);
    for (int h = 0; h < n_hdr; h++) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) r.push_back(CH_CR);
        else r.push_back(printable_char());
      end
      r.push_back(CH_CR);
      r.push_back(CH_LF);
    end
    r.push_back(CH_CR);
    r.push_back(CH_LF);
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) r.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, r.size() - 1);
      case ($urandom_range(0, 4))
        0:       r[pos] = 8'($urandom_range(0, 255));
        1:       r[pos] = CH_CR;
        2:       r[pos] = CH_LF;
        3:       r.delete(pos);
        default: r.insert(pos, CH_CR);
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) add_item(8'($urandom_range(0, 255)), 1'b0);
    end
    first_restart = ($urandom_range(0, 9) != 0);
    foreach (r[i]) add_item(r[i], (i == 0) ? first_restart : ($urandom_range(0, 199) == 0));
  endtask

  always @(posedge clk) begin
    logic     send_now;
    rx_item_t it;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_wait = 0;
      restart_parse();
    end else begin
      send_now = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        predicted_bytes.push_back(predict_parse(in_if.data_byte, in_if.new_response));
        accepted_cnt++;
        send_wait = draw_wait(accepted_cnt);
        send_now  = 1'b0;
      end
      if (!send_now) begin
        if (accepted_cnt % DRAIN_EVERY == 0 && accepted_cnt != 0 &&
            predicted_bytes.size() != 0) begin
          // hold until the parser has drained
        end else if (send_wait > 0) begin
          send_wait--;
        end else if (rx_bytes.size() != 0) begin
          it = rx_bytes.pop_front();
          in_if.data_byte    <= it.data;
          in_if.new_response <= it.restart;
          send_now = 1'b1;
        end
      end
      in_if.valid <= send_now;
    end
  end

  always @(posedge clk) begin
    byte_class_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        taken_cnt++;
        take_wait = draw_wait(taken_cnt + 32);
        if (predicted_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0h", out_if.out_byte);
          mismatches++;
        end else begin
          want = predicted_bytes.pop_front();
          if (out_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_if.out_byte);
            mismatches++;
          end
          if (out_if.is_body !== want.is_body) begin
            $error("is_body: expected %0b, got %0b", want.is_body, out_if.is_body);
            mismatches++;
          end
          if (out_if.line_end !== want.line_end) begin
            $error("line_end: expected %0b, got %0b", want.line_end, out_if.line_end);
            mismatches++;
          end
          if (out_if.headers_done !== want.headers_done) begin
            $error("headers_done: expected %0b, got %0b", want.headers_done,
                   out_if.headers_done);
            mismatches++;
          end
          if (out_if.parse_error !== want.parse_error) begin
            $error("parse_error: expected %0b, got %0b", want.parse_error, out_if.parse_error);
            mismatches++;
          end
          if (out_if.minor_version !== want.minor_version) begin
            $error("minor_version: expected %0b, got %0b", want.minor_version,
                   out_if.minor_version);
            mismatches++;
          end
          if (out_if.status_code !== want.status_code) begin
            $error("status_code: expected %0d, got %0d", want.status_code, out_if.status_code);
            mismatches++;
          end
        end
      end
      if (take_wait > 0) begin
        take_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.new_response = 1'b0;
    out_if.ready       = 1'b0;
    accepted_cnt       = 0;
    taken_cnt          = 0;
    mismatches         = 0;

    add_text("HTTP/1.0 999 ~", 1'b1);
    add_crlf();
    add_crlf();
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(CH_LF, 1'b1);
    add_item(8'h41, 1'b0);
    add_text("HTTP/1.1 001 A", 1'b1);
    add_crlf();
    while (rx_bytes.size() < RANDOM_ITEMS) add_response();
    total_items = rx_bytes.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_items) @(posedge clk);
    while (predicted_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
